@@ hw/rtl/stp_pkg.sv @@
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the string to integer parser.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int CHAR_WIDTH      = 8;

  typedef logic [CHAR_WIDTH-1:0] char_t;

  typedef enum logic [3:0] {
    PH_BLANK  = 4'b0001,
    PH_SIGNED = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_BASE    = 2'd2
  } status_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UF    = 8'h46;
  localparam char_t CH_UX    = 8'h58;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LF    = 8'h66;
  localparam char_t CH_LX    = 8'h78;

endpackage

@@ hw/rtl/stp_step.sv @@
// ----------------------------------------------------------------------------
// stp_step
// Next parse state for one non-terminator character: phase, sign, base,
// accumulator update and first error.
// ----------------------------------------------------------------------------
module stp_step #(
  parameter int VALUE_WIDTH = stp_pkg::VALUE_WIDTH_DEF
) (
  input  stp_pkg::char_t           char_i,
  input  stp_pkg::phase_t          phase_i,
  input  logic                     neg_i,
  input  logic                     hex_i,
  input  logic [VALUE_WIDTH-1:0]   acc_i,
  input  stp_pkg::status_t         err_i,
  output stp_pkg::phase_t          phase_o,
  output logic                     neg_o,
  output logic                     hex_o,
  output logic [VALUE_WIDTH-1:0]   acc_o,
  output stp_pkg::status_t         err_o
);
  import stp_pkg::*;

  logic                   is_dec;
  logic                   is_low;
  logic                   is_up;
  logic [3:0]             dig;
  logic [VALUE_WIDTH-1:0] dig_ext;
  logic [VALUE_WIDTH-1:0] acc_dec;
  logic [VALUE_WIDTH-1:0] acc_hex;
  logic                   take_dig;

  assign is_dec  = (char_i >= CH_0) && (char_i <= CH_9);
  assign is_low  = (char_i >= CH_LA) && (char_i <= CH_LF);
  assign is_up   = (char_i >= CH_UA) && (char_i <= CH_UF);

  always_comb begin
    dig = 4'd0;
    if (is_dec) begin
      dig = 4'(char_i - CH_0);
    end else if (is_low) begin
      dig = 4'(char_i - CH_LA + 8'd10);
    end else if (is_up) begin
      dig = 4'(char_i - CH_UA + 8'd10);
    end
  end

  assign dig_ext = VALUE_WIDTH'(dig);
  assign acc_dec = (acc_i << 3) + (acc_i << 1) + dig_ext;
  assign acc_hex = (acc_i << 4) | dig_ext;

  always_comb begin
    phase_o  = phase_i;
    neg_o    = neg_i;
    hex_o    = hex_i;
    acc_o    = acc_i;
    err_o    = err_i;
    take_dig = 1'b0;
    if (err_i == ST_OK) begin
      case (phase_i)
        PH_BLANK: begin
          if ((char_i == CH_SPACE) || (char_i == CH_TAB)) begin
            phase_o = PH_BLANK;
          end else if (char_i == CH_MINUS) begin
            neg_o   = 1'b1;
            phase_o = PH_SIGNED;
          end else if (char_i == CH_PLUS) begin
            phase_o = PH_SIGNED;
          end else if (char_i == CH_0) begin
            phase_o = PH_ZERO;
          end else begin
            take_dig = 1'b1;
          end
        end
        PH_SIGNED: begin
          if (char_i == CH_0) begin
            phase_o = PH_ZERO;
          end else begin
            take_dig = 1'b1;
          end
        end
        PH_ZERO: begin
          if ((char_i == CH_LX) || (char_i == CH_UX)) begin
            hex_o   = 1'b1;
            phase_o = PH_DIGITS;
          end else begin
            take_dig = 1'b1;
          end
        end
        default: begin
          take_dig = 1'b1;
        end
      endcase
      if (take_dig) begin
        phase_o = PH_DIGITS;
        if (!(is_dec || is_low || is_up)) begin
          err_o = ST_BADCHAR;
        end else if (!hex_i && !is_dec) begin
          err_o = ST_BASE;
        end else begin
          acc_o = hex_i ? acc_hex : acc_dec;
        end
      end
    end
  end

endmodule

@@ hw/rtl/string_to_integer_parser.sv @@
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming ASCII decimal / hex string to signed integer converter.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one character per transfer on in_char_in (in_valid / in_stall).
//   Leading blanks, one sign and an optional 0x / 0X prefix are handled;
//   a zero byte ends the string and produces exactly one result transfer
//   on out_status / out_value_out (out_valid / out_stall). Other bytes
//   produce no result. On error out_value_out is 0.
//   Throughput: one character per cycle while in_stall is low. The result
//   of a terminator passes through the input register and then the
//   result register; the accumulator takes one shift-add step (shift-or
//   for hex) per character.
//   While out_stall holds a pending result, characters still flow into
//   the parse state; only a following terminator waits in the input
//   register and then raises in_stall.
//   Reset clears the valid bits of both registers and the parse state;
//   the next character starts a new string.
// ----------------------------------------------------------------------------
module string_to_integer_parser #(
  parameter int VALUE_WIDTH = stp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  stp_pkg::char_t                      in_char_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [stp_pkg::OUT_WIDTH-1:0] out_value_out
);
  import stp_pkg::*;

  logic                   in_valid_r;
  char_t                  in_char_r;
  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic                   neg_r;
  logic                   neg_nxt;
  logic                   hex_r;
  logic                   hex_nxt;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [VALUE_WIDTH-1:0] acc_nxt;
  status_t                err_r;
  status_t                err_nxt;
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [OUT_WIDTH-1:0]   out_value_r;
  logic [VALUE_WIDTH-1:0] acc_signed;
  logic                   is_term;
  logic                   out_free;
  logic                   take;

  stp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .char_i (in_char_r),
    .phase_i(phase_r),
    .neg_i  (neg_r),
    .hex_i  (hex_r),
    .acc_i  (acc_r),
    .err_i  (err_r),
    .phase_o(phase_nxt),
    .neg_o  (neg_nxt),
    .hex_o  (hex_nxt),
    .acc_o  (acc_nxt),
    .err_o  (err_nxt)
  );

  assign is_term    = (in_char_r == CH_NUL);
  assign out_free   = !out_valid_r || !out_stall;
  assign take       = in_valid_r && (!is_term || out_free);
  assign in_stall   = in_valid_r && !take;
  assign acc_signed = neg_r ? (VALUE_WIDTH'(0) - acc_r) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_char_r <= in_char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLANK;
      neg_r   <= 1'b0;
      hex_r   <= 1'b0;
      acc_r   <= '0;
      err_r   <= ST_OK;
    end else if (take) begin
      if (is_term) begin
        phase_r <= PH_BLANK;
        neg_r   <= 1'b0;
        hex_r   <= 1'b0;
        acc_r   <= '0;
        err_r   <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        hex_r   <= hex_nxt;
        acc_r   <= acc_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r && is_term;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_valid_r && is_term) begin
      out_status_r <= err_r;
      out_value_r  <= (err_r == ST_OK) ? OUT_WIDTH'(acc_signed) : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = $signed(out_value_r);

endmodule
